// ----- hw/rtl/crt_pkg.sv -----
// ----------------------------------------------------------------------------
// crt_pkg: shared types and constants for the content registration table
// Request and response layouts, opcode and status codes, the table entry
// layout, the controller state encoding and the controller/datapath interface.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int CRT_TABLE_DEPTH = 16;
  localparam int CRT_NAME_BYTES  = 8;

  localparam int KEY_W  = 64;
  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;

  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_DEREGISTER = 3'd1,
    OP_SEARCH     = 3'd2,
    OP_QUIT       = 3'd3,
    OP_LIST       = 3'd4
  } opcode_e;

  typedef enum logic [3:0] {
    STS_REGISTERED   = 4'd0,
    STS_DUPLICATE    = 4'd1,
    STS_FULL         = 4'd2,
    STS_DEREGISTERED = 4'd3,
    STS_NOT_HELD     = 4'd4,
    STS_FOUND        = 4'd5,
    STS_NOT_FOUND    = 4'd6,
    STS_QUIT_OK      = 4'd7,
    STS_QUIT_REFUSED = 4'd8,
    STS_LIST_ITEM    = 4'd9
  } status_e;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [KEY_W-1:0]  owner_key;
    logic [KEY_W-1:0]  content_key;
    logic [ADDR_W-1:0] source_address;
    logic [PORT_W-1:0] service_port;
  } req_t;

  typedef struct packed {
    logic [3:0]        status;
    logic              item_valid;
    logic [KEY_W-1:0]  found_content;
    logic [KEY_W-1:0]  found_owner;
    logic [ADDR_W-1:0] found_address;
    logic [PORT_W-1:0] found_port;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]  content;
    logic [KEY_W-1:0]  owner;
    logic [ADDR_W-1:0] address;
    logic [PORT_W-1:0] port;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_RESOLVE,
    S_LIST_READ,
    S_LIST_EMIT,
    S_LIST_EMPTY
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
    logic list_step;
    logic list_emit;
    logic list_empty;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic scan_end;
    logic cur_valid;
    logic rem_any;
    logic list_last;
  } sts_t;

endpackage

// ----- hw/rtl/content_registration_table.sv -----
// ----------------------------------------------------------------------------
// content_registration_table: registry of content keys held by peers
// The block takes one request at a time on the req channel and answers on
// the rsp channel. Register, deregister, search and quit each read the whole
// table through its single read port, one entry per cycle, so the response is
// loaded once the last entry has been compared and the output register is
// free, and the next request is taken on the cycle after that load. A list
// request walks the valid bits, stepping past each free slot; each valid
// entry is read and then emitted as one response transaction; the final
// entry carries last, and an empty table gives a single list response with
// item_valid low. Responses wait in an output register under rsp_stall; a
// waiting response does not block the next request. Opcodes above list are
// accepted and produce no response. Keys are compared and stored masked to
// NAME_BYTES bytes.
// ----------------------------------------------------------------------------
module content_registration_table
  import crt_pkg::*;
#(
  parameter int TABLE_DEPTH = CRT_TABLE_DEPTH,
  parameter int NAME_BYTES  = CRT_NAME_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t cmd;
  sts_t sts;

  crt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_opcode (req.opcode),
    .sts        (sts),
    .req_stall  (req_stall),
    .cmd        (cmd)
  );

  crt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NAME_BYTES  (NAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // The controller issues at most one datapath command per cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.scan, cmd.finish, cmd.list_step, cmd.list_emit,
              cmd.list_empty}))
    else $error("more than one datapath command in a cycle");

  // A response is never loaded over one that is still stalled.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish || cmd.list_emit || cmd.list_empty) |-> sts.out_free)
    else $error("response loaded while output register is held");

  // Each list emit shows up as a valid list item on the next cycle.
  a_list_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.list_emit |=> (rsp_valid && rsp.item_valid && rsp.status == STS_LIST_ITEM))
    else $error("list emit did not produce a list item response");
`endif

endmodule

// ----- hw/rtl/crt_ctrl.sv -----
// ----------------------------------------------------------------------------
// crt_ctrl: request sequencer for the content registration table
// Accepts one request at a time, steps the datapath through the table scan
// or the list walk, and issues the response load when the output is free.
// ----------------------------------------------------------------------------
module crt_ctrl
  import crt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [2:0] req_opcode,
  input  sts_t       sts,
  output logic       req_stall,
  output cmd_t       cmd
);

  ctrl_state_e state;
  ctrl_state_e state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.start = 1'b1;
          unique case (req_opcode) inside
            OP_REGISTER, OP_DEREGISTER, OP_SEARCH, OP_QUIT: state_next = S_SCAN;
            OP_LIST:                                        state_next = S_LIST_READ;
            default:                                        state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_next = S_FLUSH;
        end
      end
      // The last entry read is still being compared.
      S_FLUSH: begin
        state_next = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LIST_READ: begin
        if (!sts.rem_any) begin
          state_next = S_LIST_EMPTY;
        end else if (sts.cur_valid) begin
          state_next = S_LIST_EMIT;
        end else begin
          cmd.list_step = 1'b1;
        end
      end
      S_LIST_EMIT: begin
        if (sts.out_free) begin
          cmd.list_emit = 1'b1;
          state_next    = sts.list_last ? S_IDLE : S_LIST_READ;
        end
      end
      S_LIST_EMPTY: begin
        if (sts.out_free) begin
          cmd.list_empty = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/crt_dp.sv -----
// ----------------------------------------------------------------------------
// crt_dp: table storage, scan compare and response register
// Holds the entry memory and its valid bits, compares one entry per cycle
// against the captured request, and builds responses into an output register.
// ----------------------------------------------------------------------------
module crt_dp
  import crt_pkg::*;
#(
  parameter int TABLE_DEPTH = CRT_TABLE_DEPTH,
  parameter int NAME_BYTES  = CRT_NAME_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam logic [KEY_W-1:0] KeyMask =
    KEY_W'((65'd1 << (8 * NAME_BYTES)) - 65'd1);

  entry_t mem [TABLE_DEPTH];
  entry_t rdata;

  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] ge_mask;
  logic [TABLE_DEPTH-1:0] gt_mask;

  req_t            req_q;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] cmp_idx;
  logic            cmp_en;
  logic            hit;
  logic [IdxW-1:0] hit_idx;
  entry_t          hit_entry;
  logic            free_found;
  logic [IdxW-1:0] free_idx;
  logic            out_full;
  rsp_t            out_q;
  rsp_t            out_next;

  logic v_cmp;
  logic owner_eq;
  logic content_eq;
  logic match;
  logic load_out;
  logic do_insert;
  logic do_remove;
  logic above_any;

  assign v_cmp      = valid[cmp_idx];
  assign owner_eq   = (rdata.owner == req_q.owner_key);
  assign content_eq = (rdata.content == req_q.content_key);

  always_comb begin
    unique case (req_q.opcode) inside
      OP_REGISTER, OP_DEREGISTER: match = v_cmp & owner_eq & content_eq;
      OP_SEARCH:                  match = v_cmp & content_eq;
      OP_QUIT:                    match = v_cmp & owner_eq;
      default:                    match = 1'b0;
    endcase
  end

  assign do_insert = cmd.finish && (req_q.opcode == OP_REGISTER) && !hit && free_found;
  assign do_remove = cmd.finish && (req_q.opcode == OP_DEREGISTER) && hit;
  assign load_out  = cmd.finish | cmd.list_emit | cmd.list_empty;

  // Masks of the slots at or above, and strictly above, the list position.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ge_mask[i] = (IdxW'(i) >= idx);
      gt_mask[i] = (IdxW'(i) > idx);
    end
  end

  assign above_any = |(valid & gt_mask);

  assign sts.out_free  = !out_full || !rsp_stall;
  assign sts.scan_end  = (idx == IdxW'(TABLE_DEPTH - 1));
  assign sts.cur_valid = valid[idx];
  assign sts.rem_any   = |(valid & ge_mask);
  assign sts.list_last = !above_any;

  always_ff @(posedge clk) begin
    rdata <= mem[idx];
    if (do_insert) begin
      mem[free_idx] <= '{content: req_q.content_key, owner: req_q.owner_key,
                         address: req_q.source_address, port: req_q.service_port};
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= idx;
    if (cmd.start) begin
      req_q.opcode         <= req.opcode;
      req_q.owner_key      <= req.owner_key & KeyMask;
      req_q.content_key    <= req.content_key & KeyMask;
      req_q.source_address <= req.source_address;
      req_q.service_port   <= req.service_port;
    end
    if (cmp_en && match) begin
      hit_idx   <= cmp_idx;
      hit_entry <= rdata;
    end
    if (cmp_en && !v_cmp && !free_found) begin
      free_idx <= cmp_idx;
    end
    if (load_out) begin
      out_q <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      cmp_en     <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      valid      <= '0;
      out_full   <= 1'b0;
    end else begin
      cmp_en <= cmd.scan;
      if (cmd.start) begin
        idx <= '0;
      end else if ((cmd.scan && !sts.scan_end) || cmd.list_step || cmd.list_emit) begin
        idx <= idx + IdxW'(1);
      end
      if (cmd.start) begin
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else if (cmp_en) begin
        if (match) begin
          hit <= 1'b1;
        end
        if (!v_cmp) begin
          free_found <= 1'b1;
        end
      end
      if (do_insert) begin
        valid[free_idx] <= 1'b1;
      end
      if (do_remove) begin
        valid[hit_idx] <= 1'b0;
      end
      out_full <= load_out | (out_full & rsp_stall);
    end
  end

  always_comb begin
    out_next      = '0;
    out_next.last = 1'b1;
    if (cmd.list_emit) begin
      out_next.status        = STS_LIST_ITEM;
      out_next.item_valid    = 1'b1;
      out_next.found_content = rdata.content;
      out_next.last          = !above_any;
    end else if (cmd.list_empty) begin
      out_next.status = STS_LIST_ITEM;
    end else begin
      unique case (req_q.opcode) inside
        OP_REGISTER: begin
          if (hit) begin
            out_next.status = STS_DUPLICATE;
          end else if (free_found) begin
            out_next.status = STS_REGISTERED;
          end else begin
            out_next.status = STS_FULL;
          end
        end
        OP_DEREGISTER: begin
          out_next.status = hit ? STS_DEREGISTERED : STS_NOT_HELD;
        end
        OP_SEARCH: begin
          if (hit) begin
            out_next.status        = STS_FOUND;
            out_next.item_valid    = 1'b1;
            out_next.found_content = hit_entry.content;
            out_next.found_owner   = hit_entry.owner;
            out_next.found_address = hit_entry.address;
            out_next.found_port    = hit_entry.port;
          end else begin
            out_next.status = STS_NOT_FOUND;
          end
        end
        OP_QUIT: begin
          out_next.status = hit ? STS_QUIT_REFUSED : STS_QUIT_OK;
        end
        default: begin
          out_next.status = STS_NOT_FOUND;
        end
      endcase
    end
  end

  assign rsp_valid = out_full;
  assign rsp       = out_q;

endmodule
